/* rtl/bed_pkg.sv */
// Shared types, constants and helpers for the button event detector.
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

    // Elapsed-time counter width, legal range 8 to 33
    localparam int COUNT_WIDTH = 17;

    // Configuration field widths
    localparam int TICK_W   = 10;
    localparam int THRESH_W = 16;
    localparam int WINDOW_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream byte widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // Internal widths for saturating add and threshold compares
    localparam int SUM_W = ((COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W) + 1;
    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW  = 2'd2;

    // Register reset values
    localparam logic [TICK_W-1:0]   TICK_PERIOD_RST = 10'd10;
    localparam logic [THRESH_W-1:0] LONG_THRESH_RST = 16'd1000;
    localparam logic [WINDOW_W-1:0] DBL_WINDOW_RST  = 16'd300;

    // Reported event codes
    typedef enum logic [1:0] {
        EV_SINGLE = 2'd0,
        EV_LONG   = 2'd1,
        EV_DOUBLE = 2'd2
    } event_t;

    // Button phase, one-hot
    typedef enum logic [4:0] {
        PH_RELEASED     = 5'b00001,
        PH_DEBOUNCE     = 5'b00010,
        PH_HELD         = 5'b00100,
        PH_WAIT_SECOND  = 5'b01000,
        PH_WAIT_RELEASE = 5'b10000
    } phase_t;

    // Live configuration
    typedef struct packed {
        logic [TICK_W-1:0]   tick_period;
        logic [THRESH_W-1:0] long_press_threshold;
        logic [WINDOW_W-1:0] double_press_window;
    } cfg_t;

    // Result of one processed item
    typedef struct packed {
        logic   valid;
        event_t code;
    } result_t;

    // Counter plus tick period, clamped at the counter maximum
    function automatic count_t sat_add(input count_t count, input logic [TICK_W-1:0] inc);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(count) + SUM_W'(inc);
            if (sum > SUM_W'(COUNT_MAX))
                sat_add = COUNT_MAX;
            else
                sat_add = sum[COUNT_WIDTH-1:0];
        end
    endfunction

    // count >= limit
    function automatic logic count_ge(input count_t count, input logic [THRESH_W-1:0] limit);
        count_ge = CMP_W'(count) >= CMP_W'(limit);
    endfunction

    // count > limit
    function automatic logic count_gt(input count_t count, input logic [WINDOW_W-1:0] limit);
        count_gt = CMP_W'(count) > CMP_W'(limit);
    endfunction

endpackage

`default_nettype wire

/* rtl/bed_cfg_regs.sv */
// Configuration register file for the button event detector.
`timescale 1ns / 1ps
`default_nettype none

module bed_cfg_regs
    import bed_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TICK_PERIOD: cfg_next.tick_period          = cfg_data[TICK_W-1:0];
                REG_LONG_THRESH: cfg_next.long_press_threshold = cfg_data[THRESH_W-1:0];
                REG_DBL_WINDOW:  cfg_next.double_press_window  = cfg_data[WINDOW_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period          <= TICK_PERIOD_RST;
            cfg_reg.long_press_threshold <= LONG_THRESH_RST;
            cfg_reg.double_press_window  <= DBL_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bed_input_stage.sv */
// Input register: captures one sampled pin level per item.
`timescale 1ns / 1ps
`default_nettype none

module bed_input_stage
    import bed_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                 advance,
    output logic                      item_valid,
    output logic                      item_pin
);

    logic valid_reg;
    logic valid_next;
    logic pin_reg;

    // Free when empty or when the held item is consumed this cycle
    assign s_axis_tready = !valid_reg || advance;
    assign item_valid    = valid_reg;
    assign item_pin      = pin_reg;

    always_comb
    begin
        if (s_axis_tready)
            valid_next = s_axis_tvalid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            pin_reg <= s_axis_tdata[0];
    end

endmodule

`default_nettype wire

/* rtl/bed_fsm.sv */
// Phase machine and saturating time counters for the button event detector.
`timescale 1ns / 1ps
`default_nettype none

module bed_fsm
    import bed_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic fire,
    input  wire logic pin,
    output result_t   result
);

    phase_t phase_reg;
    phase_t phase_next;
    count_t held_reg;
    count_t held_next;
    count_t gap_reg;
    count_t gap_next;
    count_t held_inc;
    count_t gap_inc;

    assign held_inc = sat_add(held_reg, cfg.tick_period);
    assign gap_inc  = sat_add(gap_reg, cfg.tick_period);

    // Next state and event for the current item
    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        gap_next     = gap_reg;
        result.valid = 1'b0;
        result.code  = EV_SINGLE;
        case (phase_reg)
            PH_DEBOUNCE:
            begin
                phase_next = pin ? PH_HELD : PH_RELEASED;
            end
            PH_HELD:
            begin
                if (!pin)
                begin
                    phase_next = PH_WAIT_SECOND;
                end
                else
                begin
                    held_next = held_inc;
                    if (count_ge(held_inc, cfg.long_press_threshold))
                    begin
                        result.valid = 1'b1;
                        result.code  = EV_LONG;
                        phase_next   = PH_WAIT_RELEASE;
                    end
                end
            end
            PH_WAIT_SECOND:
            begin
                gap_next = gap_inc;
                if (pin)
                begin
                    result.valid = 1'b1;
                    result.code  = EV_DOUBLE;
                    phase_next   = PH_WAIT_RELEASE;
                end
                else if (count_gt(gap_inc, cfg.double_press_window))
                begin
                    result.valid = 1'b1;
                    result.code  = EV_SINGLE;
                    phase_next   = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE:
            begin
                if (!pin)
                begin
                    held_next  = '0;
                    gap_next   = '0;
                    phase_next = PH_RELEASED;
                end
            end
            default:
            begin
                phase_next = pin ? PH_DEBOUNCE : PH_RELEASED;
            end
        endcase
        // Result only counts when the item is actually processed
        result.valid = result.valid && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RELEASED;
            held_reg  <= '0;
            gap_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            gap_reg   <= gap_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bed_output_stage.sv */
// Output register holding one event item for the downstream stream.
`timescale 1ns / 1ps
`default_nettype none

module bed_output_stage
    import bed_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire result_t               result,
    output logic                       can_load,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic   valid_reg;
    logic   valid_next;
    event_t code_reg;

    // Slot is free when empty or being drained
    assign can_load      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, code_reg};

    always_comb
    begin
        if (can_load)
            valid_next = result.valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (can_load && result.valid)
            code_reg <= result.code;
    end

endmodule

`default_nettype wire

/* rtl/button_event_detector.sv */
// Top level: single, double and long press detector for one button.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[0] pin_level
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[1:0] event_code
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled. A taken item
// waits in the input register until the output register can take its result;
// it is then processed and its event, if any, loads into the output register.
// The phase machine and both counter adders sit between the input register
// and the output register. A stalled output holds the input register, and
// the input side accepts while its register is empty or the held item moves on.
// Reset clears phase and counters and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module button_event_detector
    import bed_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [1:0] event_code, [7:2] zero
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t result;
    logic    item_valid;
    logic    item_pin;
    logic    can_load;
    logic    fire;

    // An item is processed when the output slot can take its result
    assign fire = item_valid && can_load;

    bed_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bed_input_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (fire),
        .item_valid    (item_valid),
        .item_pin      (item_pin)
    );

    bed_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .pin    (item_pin),
        .result (result)
    );

    bed_output_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* tb/tb_button_event_detector.sv */
// Self-checking testbench for the button event detector: directed rows, then random gestures.
`timescale 1ns / 1ps

module tb_button_event_detector;
    import bed_pkg::*;

    // Run limits
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_CYCLES = 60;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 60;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum logic { ROW_PIN, ROW_CFG } row_kind_t;

    // One row of the directed stimulus
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  pin;
        bit                    typed;
        event_t                code;
    } row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_tvalid      = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata       = '0;
    logic                  m_tready      = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire [OUT_DATA_W-1:0]  m_axis_tdata;
    wire                   cfg_ready;

    button_event_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predicted button state and live settings
    phase_t              btn_phase  = PH_RELEASED;
    count_t              held_ms    = '0;
    count_t              gap_ms     = '0;
    logic [TICK_W-1:0]   cfg_tick   = TICK_PERIOD_RST;
    logic [THRESH_W-1:0] cfg_thresh = LONG_THRESH_RST;
    logic [WINDOW_W-1:0] cfg_window = DBL_WINDOW_RST;

    // Events still owed by the block, oldest first
    event_t event_q [$];

    int  errors     = 0;
    int  sent       = 0;
    int  checked    = 0;
    int  cycles     = 0;
    int  gap_pct    = 30;
    bit  quiet      = 1'b0;
    bit  stall_req  = 1'b0;

    row_t dir_rows [$];

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d events outstanding",
                 $time, cycles, event_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Counter plus tick period, clamped at the counter top
    function automatic count_t bump(input count_t c);
        logic [39:0] s;
        s = 40'(c) + 40'(cfg_tick);
        bump = (s > 40'(COUNT_MAX)) ? COUNT_MAX : count_t'(s);
    endfunction

    // Advance the predicted button machine by one tick
    task automatic button_tick(input logic pin, output bit fired, output event_t code);
        fired = 1'b0;
        code  = EV_SINGLE;
        case (btn_phase)
            PH_DEBOUNCE:
                btn_phase = pin ? PH_HELD : PH_RELEASED;
            PH_HELD:
                if (!pin)
                    btn_phase = PH_WAIT_SECOND;
                else
                begin
                    held_ms = bump(held_ms);
                    if (40'(held_ms) >= 40'(cfg_thresh))
                    begin
                        fired     = 1'b1;
                        code      = EV_LONG;
                        btn_phase = PH_WAIT_RELEASE;
                    end
                end
            PH_WAIT_SECOND:
            begin
                gap_ms = bump(gap_ms);
                if (pin)
                begin
                    fired     = 1'b1;
                    code      = EV_DOUBLE;
                    btn_phase = PH_WAIT_RELEASE;
                end
                else if (40'(gap_ms) > 40'(cfg_window))
                begin
                    fired     = 1'b1;
                    code      = EV_SINGLE;
                    btn_phase = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE:
                if (!pin)
                begin
                    held_ms   = '0;
                    gap_ms    = '0;
                    btn_phase = PH_RELEASED;
                end
            default:
                btn_phase = pin ? PH_DEBOUNCE : PH_RELEASED;
        endcase
    endtask

    // Offer one tick, wait for it to be taken, queue what it causes
    task automatic drive_tick(input logic lvl, input bit typed, input event_t typed_code);
        bit     fired;
        event_t code;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, lvl};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
        button_tick(lvl, fired, code);
        if (typed)
        begin
            if (!fired || code != typed_code)
            begin
                $display("%0t: table row disagrees with prediction: expected %0d, got %0d",
                         $time, typed_code, fired ? int'(code) : -1);
                errors++;
            end
            event_q.push_back(typed_code);
        end
        else if (fired)
            event_q.push_back(code);
        // random idle burst on the input side
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until the block has nothing left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        while (event_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; valid is dropped only after the last of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TICK_PERIOD: cfg_tick   = data[TICK_W-1:0];
            REG_LONG_THRESH: cfg_thresh = data[THRESH_W-1:0];
            REG_DBL_WINDOW:  cfg_window = data[WINDOW_W-1:0];
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    function automatic row_t pin_row(input logic lvl);
        pin_row = '{ROW_PIN, REG_NONE, '0, lvl, 1'b0, EV_SINGLE};
    endfunction

    function automatic row_t ev_row(input logic lvl, input event_t code);
        ev_row = '{ROW_PIN, REG_NONE, '0, lvl, 1'b1, code};
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        reg_row = '{ROW_CFG, idx, data, 1'b0, 1'b0, EV_SINGLE};
    endfunction

    // Output side: check every taken event, idle in bursts, one long hold-off
    initial
    begin
        int burst_left;
        int stall_left;
        burst_left = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_tready)
            begin
                if (event_q.size() == 0)
                begin
                    $display("%0t: unexpected event: expected none, got %0d",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    event_t want;
                    want = event_q.pop_front();
                    checked++;
                    if (m_axis_tdata !== OUT_DATA_W'(want))
                    begin
                        $display("%0t: event mismatch: expected %0d, got %0d",
                                 $time, want, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (stall_req)
            begin
                stall_req  = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        int          tk;
        int          th;
        int          wn;
        int          ph_start;
        int          hold_n;
        int          gap_n;
        int          len;
        bit          stall_done;
        logic [15:0] tk_w;

        stall_done = 1'b0;

        // Defaults first, then window 0, zero tick, masked maximum tick, equality at the window
        dir_rows = '{
            pin_row(1), pin_row(1), pin_row(0), ev_row(1, EV_DOUBLE), pin_row(0),
            pin_row(1), pin_row(0),
            reg_row(REG_NONE, 16'hFFFF), reg_row(REG_DBL_WINDOW, 16'd0),
            pin_row(1), pin_row(1), pin_row(0), ev_row(0, EV_SINGLE), pin_row(0),
            reg_row(REG_TICK_PERIOD, 16'd0), reg_row(REG_LONG_THRESH, 16'd0),
            pin_row(1), pin_row(1), ev_row(1, EV_LONG), pin_row(0),
            reg_row(REG_TICK_PERIOD, 16'hFFFF), reg_row(REG_LONG_THRESH, 16'hFFFF),
            reg_row(REG_DBL_WINDOW, 16'hFFFF),
            pin_row(1), pin_row(1), pin_row(0), ev_row(1, EV_DOUBLE), pin_row(0),
            reg_row(REG_TICK_PERIOD, 16'd1000), reg_row(REG_LONG_THRESH, 16'd2000),
            reg_row(REG_DBL_WINDOW, 16'd1000),
            pin_row(1), pin_row(1), pin_row(0), pin_row(0), ev_row(0, EV_SINGLE), pin_row(0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || dir_rows[i-1].kind != ROW_CFG)
                    settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data,
                          i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG);
            end
            else
                drive_tick(dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].code);
        end

        // Random phases, one setting each
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            case (p)
                2: begin tk = 0;    th = 0;     wn = $urandom_range(0, 3000); end
                3: begin tk = 1023; th = 65535; wn = 65535;                   end
                4: begin tk = 1;    th = $urandom_range(0, 8); wn = $urandom_range(0, 6); end
                5: begin tk = 1000; th = 0;     wn = 0;                       end
                default:
                begin
                    tk = $urandom_range(1, 1000);
                    th = tk * $urandom_range(0, 8) + $urandom_range(0, tk - 1);
                    wn = tk * $urandom_range(0, 6) + $urandom_range(0, tk - 1);
                end
            endcase
            if (th > 65535) th = 65535;
            if (wn > 65535) wn = 65535;
            // top tick value also exercises masking of the upper data bits
            tk_w = (p == 3) ? 16'hFFFF : 16'(tk);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, 16'($urandom_range(0, 65535)), 1'b0);
            write_reg(REG_TICK_PERIOD, tk_w, 1'b0);
            write_reg(REG_LONG_THRESH, 16'(th), 1'b0);
            write_reg(REG_DBL_WINDOW, 16'(wn), 1'b1);

            gap_pct  = (p == 1 || p == 7) ? 0 : 30;
            quiet    = (p == 7);
            ph_start = sent;
            hold_n   = (cfg_tick == 0) ? 3 : int'(cfg_thresh) / int'(cfg_tick) + 1;
            gap_n    = (cfg_tick == 0) ? 3 : int'(cfg_window) / int'(cfg_tick) + 1;
            if (hold_n > 80) hold_n = 80;
            if (gap_n > 80)  gap_n = 80;

            while (sent < ph_start + PHASE_ITEMS)
            begin
                if (p == 1 && !stall_done && sent >= ph_start + 10)
                begin
                    stall_req  = 1'b1;
                    stall_done = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    // noise
                    len = $urandom_range(1, 6);
                    repeat (len) drive_tick(1'($urandom_range(0, 1)), 1'b0, EV_SINGLE);
                end
                else
                begin
                    // one press then one release, lengths around the thresholds
                    len = $urandom_range(1, hold_n + 2);
                    repeat (len) drive_tick(1'b1, 1'b0, EV_SINGLE);
                    len = $urandom_range(1, gap_n + 2);
                    repeat (len) drive_tick(1'b0, 1'b0, EV_SINGLE);
                end
            end
        end

        // Drain and report
        settle();
        $display("Covered %0d ticks over %0d register settings; %0d events compared.",
                 sent, N_PHASES + 5, checked);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
